// File: design/apd_pkg.sv
`timescale 1ns / 1ps

package apd_pkg;

    // Depth of the TOC store and the widths that follow from it.
    localparam int MAX_TOCS  = 16;
    localparam int TOC_IDX_W = (MAX_TOCS > 1) ? $clog2(MAX_TOCS) : 1;
    localparam int TOC_CNT_W = $clog2(MAX_TOCS + 1);

    // Largest frame body and the width of the fill and read counters.
    localparam int FRAME_MAX = 31;
    localparam int FILL_W    = 5;

    // Frame types from this code upwards carry no speech frame.
    localparam logic [3:0] FIRST_BAD_TYPE = 4'd9;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_FRAME   = 3'd0,
        KIND_SHORT   = 3'd1,
        KIND_BADLIST = 3'd2,
        KIND_BADTYPE = 3'd3,
        KIND_TRUNC   = 3'd4
    } kind_t;

    // Source of the byte loaded into the output register.
    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_TOC  = 2'd1,
        SEL_DATA = 2'd2
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     end_load;
        logic     toc_clear;
        logic     toc_write;
        logic     frame_rst;
        logic     frame_inc;
        logic     fill_clear;
        logic     buf_write;
        logic     idx_clear;
        logic     idx_inc;
        logic     out_load;
        kind_t    out_kind;
        out_sel_t out_sel;
        logic     out_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic in_flag;
        logic in_end;
        logic end_seen;
        logic toc_full;
        logic bad_type;
        logic fill_done;
        logic last_data;
        logic frames_done;
    } dp_status_t;

    // Frame body size in bytes for each frame type; zero where no frame exists.
    function automatic logic [FILL_W-1:0] frame_size(input logic [3:0] ftype);
        logic [FILL_W-1:0] size;
        unique case (ftype)
            4'd0:    size = 5'd12;
            4'd1:    size = 5'd13;
            4'd2:    size = 5'd15;
            4'd3:    size = 5'd17;
            4'd4:    size = 5'd19;
            4'd5:    size = 5'd20;
            4'd6:    size = 5'd26;
            4'd7:    size = 5'd31;
            4'd8:    size = 5'd5;
            default: size = 5'd0;
        endcase
        return size;
    endfunction

endpackage

// File: design/apd_in_if.sv
`timescale 1ns / 1ps

// Payload byte channel.
interface apd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       packet_end;

    modport source (output valid, output payload_byte, output packet_end, input ready);
    modport sink   (input valid, input payload_byte, input packet_end, output ready);
endinterface

// File: design/apd_out_if.sv
`timescale 1ns / 1ps

// Result channel.
interface apd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] frame_byte;
    logic       last;

    modport source (output valid, output kind, output frame_byte, output last, input ready);
    modport sink   (input valid, input kind, input frame_byte, input last, output ready);
endinterface

// File: design/apd_datapath.sv
`timescale 1ns / 1ps

module apd_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             payload_byte,
    input  logic                   packet_end,
    input  logic                   out_ready,
    input  apd_pkg::dp_cmd_t       cmd,
    output apd_pkg::dp_status_t    status,
    output logic                   out_valid,
    output logic [2:0]             out_kind,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    logic [7:0]                     toc_mem [apd_pkg::MAX_TOCS];
    logic [7:0]                     buf_mem [apd_pkg::FRAME_MAX];
    logic [apd_pkg::TOC_CNT_W-1:0]  toc_count_reg;
    logic [apd_pkg::TOC_CNT_W-1:0]  frame_num_reg;
    logic [apd_pkg::FILL_W-1:0]     fill_reg;
    logic [apd_pkg::FILL_W-1:0]     idx_reg;
    logic                           end_reg;
    logic                           out_valid_reg;
    apd_pkg::kind_t                 out_kind_reg;
    logic [7:0]                     out_byte_reg;
    logic                           out_last_reg;

    logic [7:0]                     cur_toc;
    logic [3:0]                     cur_type;
    logic [apd_pkg::FILL_W-1:0]     cur_size;
    logic [7:0]                     load_byte;

    // TOC of the current frame; a frame beyond the stored list reads as zero.
    always_comb
    begin
        if (frame_num_reg < toc_count_reg)
        begin
            cur_toc = toc_mem[frame_num_reg[apd_pkg::TOC_IDX_W-1:0]];
        end
        else
        begin
            cur_toc = 8'd0;
        end
        cur_type = cur_toc[6:3];
        cur_size = apd_pkg::frame_size(cur_type);
    end

    // Status towards the controller.
    always_comb
    begin
        status.out_free    = !out_valid_reg || out_ready;
        status.in_flag     = payload_byte[7];
        status.in_end      = packet_end;
        status.end_seen    = end_reg;
        status.toc_full    = toc_count_reg >= apd_pkg::TOC_CNT_W'(apd_pkg::MAX_TOCS);
        status.bad_type    = cur_type >= apd_pkg::FIRST_BAD_TYPE;
        status.fill_done   = ({1'b0, fill_reg} + 6'd1) >= {1'b0, cur_size};
        status.last_data   = idx_reg == (cur_size - 5'd1);
        status.frames_done = ({1'b0, frame_num_reg} + 1'b1) >= {1'b0, toc_count_reg};
    end

    // Byte for the output register.
    always_comb
    begin
        case (cmd.out_sel)
            apd_pkg::SEL_TOC:  load_byte = cur_toc;
            apd_pkg::SEL_DATA: load_byte = buf_mem[idx_reg];
            default:           load_byte = 8'd0;
        endcase
    end

    // Counters and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toc_count_reg <= '0;
            frame_num_reg <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.toc_clear)
            begin
                toc_count_reg <= '0;
            end
            else if (cmd.toc_write)
            begin
                toc_count_reg <= toc_count_reg + 1'b1;
            end

            if (cmd.frame_rst)
            begin
                frame_num_reg <= '0;
            end
            else if (cmd.frame_inc)
            begin
                frame_num_reg <= frame_num_reg + 1'b1;
            end

            if (cmd.fill_clear)
            begin
                fill_reg <= '0;
            end
            else if (cmd.buf_write)
            begin
                fill_reg <= fill_reg + 1'b1;
            end

            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.end_load)
            begin
                end_reg <= packet_end;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stores and output payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.toc_write)
        begin
            toc_mem[toc_count_reg[apd_pkg::TOC_IDX_W-1:0]] <= payload_byte;
        end
        if (cmd.buf_write)
        begin
            buf_mem[fill_reg] <= payload_byte;
        end
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_byte_reg <= load_byte;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// File: design/apd_ctrl.sv
`timescale 1ns / 1ps

module apd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  apd_pkg::dp_status_t status,
    output apd_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_START    = 4'b0010,
        ST_TOC_OUT  = 4'b0100,
        ST_DATA_OUT = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        PH_CMR   = 4'b0001,
        PH_TOC   = 4'b0010,
        PH_FRAME = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cmd.end_load   = 1'b0;
        cmd.toc_clear  = 1'b0;
        cmd.toc_write  = 1'b0;
        cmd.frame_rst  = 1'b0;
        cmd.frame_inc  = 1'b0;
        cmd.fill_clear = 1'b0;
        cmd.buf_write  = 1'b0;
        cmd.idx_clear  = 1'b0;
        cmd.idx_inc    = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.out_kind   = apd_pkg::KIND_FRAME;
        cmd.out_sel    = apd_pkg::SEL_ZERO;
        cmd.out_last   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.end_load = 1'b1;
                    unique case (phase_reg)
                        PH_CMR:
                        begin
                            if (status.in_end)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = apd_pkg::KIND_SHORT;
                                cmd.out_last = 1'b1;
                            end
                            else
                            begin
                                cmd.toc_clear = 1'b1;
                                phase_next    = PH_TOC;
                            end
                        end
                        PH_TOC:
                        begin
                            if (status.toc_full)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = apd_pkg::KIND_BADLIST;
                                cmd.out_last = 1'b1;
                                phase_next   = status.in_end ? PH_CMR : PH_SKIP;
                            end
                            else
                            begin
                                cmd.toc_write = 1'b1;
                                if (status.in_flag)
                                begin
                                    // List runs out with the packet.
                                    if (status.in_end)
                                    begin
                                        cmd.out_load = 1'b1;
                                        cmd.out_kind = apd_pkg::KIND_BADLIST;
                                        cmd.out_last = 1'b1;
                                        phase_next   = PH_CMR;
                                    end
                                end
                                else
                                begin
                                    cmd.frame_rst = 1'b1;
                                    state_next    = ST_START;
                                end
                            end
                        end
                        PH_FRAME:
                        begin
                            cmd.buf_write = 1'b1;
                            if (status.fill_done)
                            begin
                                state_next = ST_TOC_OUT;
                            end
                            else if (status.in_end)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = apd_pkg::KIND_TRUNC;
                                cmd.out_last = 1'b1;
                                phase_next   = PH_CMR;
                            end
                        end
                        default:
                        begin
                            if (status.in_end)
                            begin
                                phase_next = PH_CMR;
                            end
                        end
                    endcase
                end
            end

            // Check the type of the next frame and whether bytes remain for it.
            ST_START:
            begin
                if (status.out_free)
                begin
                    cmd.fill_clear = 1'b1;
                    state_next     = ST_IDLE;
                    if (status.bad_type)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = apd_pkg::KIND_BADTYPE;
                        cmd.out_last = 1'b1;
                        phase_next   = status.end_seen ? PH_CMR : PH_SKIP;
                    end
                    else if (status.end_seen)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = apd_pkg::KIND_TRUNC;
                        cmd.out_last = 1'b1;
                        phase_next   = PH_CMR;
                    end
                    else
                    begin
                        phase_next = PH_FRAME;
                    end
                end
            end

            ST_TOC_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = apd_pkg::SEL_TOC;
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_DATA_OUT;
                end
            end

            default:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = apd_pkg::SEL_DATA;
                    cmd.out_last = status.last_data;
                    cmd.idx_inc  = 1'b1;
                    if (status.last_data)
                    begin
                        cmd.frame_inc = 1'b1;
                        if (status.frames_done)
                        begin
                            phase_next = status.end_seen ? PH_CMR : PH_SKIP;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_START;
                        end
                    end
                end
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_CMR;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// File: design/amr_payload_deframer_unit.sv
`timescale 1ns / 1ps

// Octet-aligned AMR-NB payload deframer. Payload bytes enter one beat at a
// time with packet_end on the final byte; the CMR byte is dropped, the TOC
// list is stored (up to 16 entries) and each frame is buffered and then sent
// out as its TOC byte followed by its body bytes, with last on the final
// byte. Errors come out as a single beat with last set and a zero byte.
// The byte that completes a frame is followed by the output of its TOC byte
// and body, read from the frame buffer one byte per cycle while the output
// takes them, and by a start step for the next frame; the byte that closes
// the TOC list also passes through that start step. Input is
// taken only while the controller is idle and the output register can take
// a beat, so a stalled output holds the input as well.
module amr_payload_deframer_unit (
    input  logic      clk,
    input  logic      rst_n,
    apd_in_if.sink    byte_in,
    apd_out_if.source res_out
);

    apd_pkg::dp_cmd_t    cmd;
    apd_pkg::dp_status_t status;

    // Sequencing of packet phases and frame emission.
    apd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_ready (byte_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // TOC store, frame buffer, counters and output register.
    apd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .payload_byte (byte_in.payload_byte),
        .packet_end   (byte_in.packet_end),
        .out_ready    (res_out.ready),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (res_out.valid),
        .out_kind     (res_out.kind),
        .out_byte     (res_out.frame_byte),
        .out_last     (res_out.last)
    );

endmodule

// File: design/apd_checker.sv
`timescale 1ns / 1ps

module apd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_byte) && $stable(out_last))
    else $error("result beat changed while stalled");

    // Every error result is a single closing beat with a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != apd_pkg::KIND_FRAME) |-> out_last && (out_byte == 8'd0))
    else $error("error result without last or with nonzero byte");

    // No payload byte is taken while a result beat is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !(out_valid && !out_ready))
    else $error("input taken while output stalled");

endmodule

bind amr_payload_deframer_unit apd_checker u_apd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_kind  (res_out.kind),
    .out_byte  (res_out.frame_byte),
    .out_last  (res_out.last)
);

// File: tb/amr_deframe_check.sv
`timescale 1ns / 1ps

// Watches both channels of the deframer, works out the result beats that each
// accepted payload byte should cause, and compares every accepted result beat
// with the oldest beat still waiting.
module amr_deframe_check (
    input  logic clk,
    input  logic rst_n,
    apd_in_if    byte_ch,
    apd_out_if   res_ch,
    output int   failures,
    output int   pending
);

    // Where the parser stands within the current packet.
    typedef enum logic [1:0] {
        AT_CMR,
        AT_TOC,
        AT_FRAME,
        AT_SKIP
    } parse_pos_t;

    typedef struct packed {
        apd_pkg::kind_t kind;
        logic [7:0]     data;
        logic           last;
    } res_beat_t;

    res_beat_t  result_fifo[$];
    res_beat_t  want;

    parse_pos_t pos;
    logic [7:0] toc_list [apd_pkg::MAX_TOCS];
    int         toc_total;
    int         frame_idx;
    logic [7:0] body [apd_pkg::FRAME_MAX];
    int         body_fill;
    int         body_len [16];

    // Body length per frame type; types nine and above carry no frame.
    initial begin
        body_len = '{12, 13, 15, 17, 19, 20, 26, 31, 5, 0, 0, 0, 0, 0, 0, 0};
    end

    function automatic void push_result(apd_pkg::kind_t k, logic [7:0] d, logic l);
        res_beat_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        result_fifo.push_back(r);
    endfunction

    // Start the frame at frame_idx: a bad type wins over a packet that has ended.
    function automatic void open_frame(logic pkt_end);
        logic [3:0] ftype;
        ftype = (frame_idx < toc_total) ? toc_list[frame_idx][6:3] : 4'd0;
        if (ftype >= 4'd9)
        begin
            push_result(apd_pkg::KIND_BADTYPE, 8'h00, 1'b1);
            pos = pkt_end ? AT_CMR : AT_SKIP;
        end
        else if (pkt_end)
        begin
            push_result(apd_pkg::KIND_TRUNC, 8'h00, 1'b1);
            pos = AT_CMR;
        end
        else
        begin
            pos = AT_FRAME;
            body_fill = 0;
        end
    endfunction

    // Advance the parser by one payload byte and queue the beats it causes.
    function automatic void take_payload_byte(logic [7:0] b, logic pkt_end);
        logic [7:0] toc;
        int         size;
        case (pos)
            AT_CMR:
            begin
                if (pkt_end)
                    push_result(apd_pkg::KIND_SHORT, 8'h00, 1'b1);
                else
                begin
                    pos = AT_TOC;
                    toc_total = 0;
                end
            end
            AT_TOC:
            begin
                if (toc_total >= apd_pkg::MAX_TOCS)
                begin
                    push_result(apd_pkg::KIND_BADLIST, 8'h00, 1'b1);
                    pos = pkt_end ? AT_CMR : AT_SKIP;
                end
                else
                begin
                    toc_list[toc_total] = b;
                    toc_total++;
                    if (b[7])
                    begin
                        if (pkt_end)
                        begin
                            push_result(apd_pkg::KIND_BADLIST, 8'h00, 1'b1);
                            pos = AT_CMR;
                        end
                    end
                    else
                    begin
                        frame_idx = 0;
                        body_fill = 0;
                        open_frame(pkt_end);
                    end
                end
            end
            AT_FRAME:
            begin
                toc = (frame_idx < toc_total) ? toc_list[frame_idx] : 8'h00;
                size = body_len[toc[6:3]];
                if (body_fill < apd_pkg::FRAME_MAX)
                begin
                    body[body_fill] = b;
                    body_fill++;
                end
                if (body_fill >= size)
                begin
                    // A complete frame goes out as its TOC byte and then its body.
                    push_result(apd_pkg::KIND_FRAME, toc, size == 0);
                    for (int i = 0; i < size && i < apd_pkg::FRAME_MAX; i++)
                        push_result(apd_pkg::KIND_FRAME, body[i], i + 1 == size);
                    frame_idx++;
                    body_fill = 0;
                    if (frame_idx >= toc_total)
                        pos = pkt_end ? AT_CMR : AT_SKIP;
                    else
                        open_frame(pkt_end);
                end
                else if (pkt_end)
                begin
                    push_result(apd_pkg::KIND_TRUNC, 8'h00, 1'b1);
                    pos = AT_CMR;
                end
            end
            default:
            begin
                if (pkt_end)
                    pos = AT_CMR;
            end
        endcase
    endfunction

    // Predict on every accepted payload beat and check every accepted result beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos = AT_CMR;
            toc_total = 0;
            frame_idx = 0;
            body_fill = 0;
            result_fifo.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                take_payload_byte(byte_ch.payload_byte, byte_ch.packet_end);
            if (res_ch.valid && res_ch.ready)
            begin
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: expected no result, got kind %0d byte %02h last %0b",
                             $time, res_ch.kind, res_ch.frame_byte, res_ch.last);
                    failures++;
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (res_ch.kind !== want.kind || res_ch.frame_byte !== want.data ||
                        res_ch.last !== want.last)
                    begin
                        $display(
                            "%0t: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                            $time, want.kind, want.data, want.last,
                            res_ch.kind, res_ch.frame_byte, res_ch.last);
                        failures++;
                    end
                end
            end
            pending = result_fifo.size();
        end
    end

endmodule

// File: tb/amr_payload_deframer_unit_test.sv
`timescale 1ns / 1ps

// Drives payload packets into the deframer, from a short directed set through
// well-formed and broken random packets, with idling on both sides, and gives
// the verdict from the failure count of the watching module.
module amr_payload_deframer_unit_test;

    // Shapes of random packet.
    localparam int SHAPE_GOOD     = 0;
    localparam int SHAPE_SHORT    = 1;
    localparam int SHAPE_RUNOUT   = 2;
    localparam int SHAPE_BADTYPE  = 3;
    localparam int SHAPE_CUT      = 4;
    localparam int SHAPE_OVERFLOW = 5;

    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int BEATS_PER_RUN = 45;

    logic clk;
    logic rst_n;

    apd_in_if  byte_ch ();
    apd_out_if res_ch ();

    int         failures;
    int         pending;
    int         items_sent = 0;
    int         src_idle_pct = 36;
    int         snk_idle_pct = 64;
    logic       hold_ask = 1'b0;
    int         hold_left = 0;
    logic [7:0] pkt[$];
    int         body_bytes [16];
    int         goal;

    amr_payload_deframer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .res_out (res_ch)
    );

    amr_deframe_check watch (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .res_ch   (res_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Ends a run that hangs.
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: random back-pressure, or a long hold when asked for one.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ask)
            begin
                hold_left = HOLD_CYCLES;
                hold_ask = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Offer one beat, idling first at random, and wait until it is taken.
    task automatic send_beat(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.payload_byte <= b;
        byte_ch.packet_end <= e;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_beat(pkt[i], i == pkt.size() - 1);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic wait_drained();
        int guard;
        guard = 0;
        byte_ch.valid <= 1'b0;
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Build a packet of the given shape with random content and send it.
    task automatic make_packet(input int shape);
        int         ntoc;
        int         bad_at;
        int         cut;
        logic [3:0] ftypes [3];
        pkt.delete();
        pkt.push_back(8'($urandom));
        case (shape)
            SHAPE_SHORT:
            begin
            end
            SHAPE_RUNOUT:
            begin
                ntoc = $urandom_range(4, 1);
                for (int i = 0; i < ntoc; i++)
                    pkt.push_back({1'b1, 7'($urandom)});
            end
            SHAPE_OVERFLOW:
            begin
                // More TOCs than the store holds, all with the follow-on bit set.
                ntoc = apd_pkg::MAX_TOCS + $urandom_range(3, 1);
                for (int i = 0; i < ntoc; i++)
                    pkt.push_back({1'b1, 4'($urandom_range(8)), 3'($urandom)});
                repeat ($urandom_range(2)) pkt.push_back(8'($urandom));
            end
            default:
            begin
                ntoc = $urandom_range(3, 1);
                bad_at = (shape == SHAPE_BADTYPE) ? $urandom_range(ntoc - 1) : ntoc;
                for (int i = 0; i < ntoc; i++)
                begin
                    if (i == bad_at)
                        ftypes[i] = 4'($urandom_range(15, 9));
                    else if ($urandom_range(1) == 0)
                        ftypes[i] = 4'd8;
                    else
                        ftypes[i] = 4'($urandom_range(7));
                    pkt.push_back({i != ntoc - 1, ftypes[i], 3'($urandom)});
                end
                for (int i = 0; i < ntoc; i++)
                    for (int j = 0; j < body_bytes[ftypes[i]]; j++)
                        pkt.push_back(8'($urandom));
                // Trailing bytes that the block must ignore.
                if (shape == SHAPE_BADTYPE || $urandom_range(3) == 0)
                    repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
                if (shape == SHAPE_CUT)
                begin
                    cut = $urandom_range(pkt.size() - 1, 2);
                    while (pkt.size() > cut)
                        void'(pkt.pop_back());
                end
            end
        endcase
        send_packet();
    endtask

    task automatic random_packet();
        int pick;
        pick = $urandom_range(99);
        if (pick < 68)
            make_packet(SHAPE_GOOD);
        else if (pick < 74)
            make_packet(SHAPE_SHORT);
        else if (pick < 81)
            make_packet(SHAPE_RUNOUT);
        else if (pick < 88)
            make_packet(SHAPE_BADTYPE);
        else if (pick < 97)
            make_packet(SHAPE_CUT);
        else
            make_packet(SHAPE_OVERFLOW);
    endtask

    // Stimulus and verdict.
    initial
    begin
        body_bytes = '{12, 13, 15, 17, 19, 20, 26, 31, 5, 0, 0, 0, 0, 0, 0, 0};
        byte_ch.valid = 1'b0;
        byte_ch.payload_byte = 8'h00;
        byte_ch.packet_end = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A packet of the CMR byte alone.
        pkt = '{8'hFF};
        send_packet();
        // The TOC list ends with the follow-on bit still set.
        pkt = '{8'h00, 8'hFF};
        send_packet();
        // Frame type fifteen, then the rest of the packet is skipped.
        pkt = '{8'h12, 8'h7F, 8'h00, 8'hAA};
        send_packet();
        // One short frame followed by a byte that is ignored.
        pkt = '{8'h00, 8'h44, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h55};
        send_packet();
        // The packet ends right after the TOC list.
        pkt = '{8'hF0, 8'h40};
        send_packet();
        // The packet ends after the first of two frames.
        pkt = '{8'h00, 8'hC7, 8'h47, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFE};
        send_packet();
        wait_drained();

        // Three runs of random packets: receiver idles more, then sender, then neither.
        for (int run = 0; run < 3; run++)
        begin
            src_idle_pct = (run == 0) ? 36 : (run == 1) ? 64 : 0;
            snk_idle_pct = (run == 0) ? 64 : (run == 1) ? 36 : 0;
            if (run == 0)
                make_packet(SHAPE_OVERFLOW);
            if (run == 2)
                hold_ask = 1'b1;
            goal = items_sent + BEATS_PER_RUN;
            while (items_sent < goal)
                random_packet();
            wait_drained();
        end

        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (failures == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: amr_payload_deframer_unit.f
design/apd_pkg.sv
design/apd_in_if.sv
design/apd_out_if.sv
design/apd_datapath.sv
design/apd_ctrl.sv
design/amr_payload_deframer_unit.sv
design/apd_checker.sv
tb/amr_deframe_check.sv
tb/amr_payload_deframer_unit_test.sv
